>>> rtl/sgl_pkg.sv
// Shared types and constants for the scatter/gather list engine.
package sgl_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int CAP_W = 7;
	localparam int ADDR_W = 64;
	localparam int LEN_W = 32;
	localparam int IN_DATA_W = 136;
	localparam int OUT_DATA_W = 96;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Operation codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_APPEND = 2'd1,
		OP_GET = 2'd2,
		OP_REWIND = 2'd3
	} sgl_op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FRAG,
		ST_CAP,
		ST_RESULT
	} sgl_state_t;

	// One table entry
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0] len;
	} sgl_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic item_ld;
		logic rd_look;
		logic rd_step;
		logic clr;
		logic rewind;
		logic app_merge;
		logic app_new;
		logic get_step;
		logic res_fail;
		logic res_zero;
		logic frag_ld;
		logic cap_ld;
		logic out_ld;
	} sgl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		sgl_op_t op;
		logic can_merge;
		logic full;
		logic get_none;
		logic rem_zero;
		logic last_pair;
	} sgl_stat_t;

endpackage

>>> rtl/sgl_ctrl.sv
// Controller state machine for the scatter/gather list engine.
module sgl_ctrl
	import sgl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  sgl_stat_t stat,
	output sgl_cmd_t cmd
);

	sgl_state_t state_q;
	sgl_state_t state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_nxt = ST_READ;
			end
			ST_READ: state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (stat.op == OP_GET && !stat.get_none
						&& !(stat.rem_zero && stat.last_pair)) begin
					state_nxt = ST_FRAG;
				end else begin
					state_nxt = ST_RESULT;
				end
			end
			ST_FRAG: state_nxt = ST_CAP;
			ST_CAP: state_nxt = ST_RESULT;
			ST_RESULT: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.item_ld = s_axis_tvalid;
			ST_READ: cmd.rd_look = 1'b1;
			ST_EVAL: begin
				case (stat.op)
					OP_CLEAR: begin
						cmd.clr = 1'b1;
						cmd.res_zero = 1'b1;
					end
					OP_REWIND: begin
						cmd.rewind = 1'b1;
						cmd.res_zero = 1'b1;
					end
					OP_APPEND: begin
						if (stat.can_merge) begin
							cmd.app_merge = 1'b1;
							cmd.res_zero = 1'b1;
						end else if (stat.full) begin
							cmd.res_fail = 1'b1;
						end else begin
							cmd.app_new = 1'b1;
							cmd.res_zero = 1'b1;
						end
					end
					OP_GET: begin
						if (stat.get_none) begin
							cmd.res_fail = 1'b1;
						end else if (stat.rem_zero) begin
							if (stat.last_pair) begin
								cmd.res_fail = 1'b1;
							end else begin
								cmd.get_step = 1'b1;
								cmd.rd_step = 1'b1;
							end
						end
					end
					default: cmd.res_fail = 1'b1;
				endcase
			end
			ST_FRAG: cmd.frag_ld = 1'b1;
			ST_CAP: cmd.cap_ld = 1'b1;
			ST_RESULT: cmd.out_ld = out_free;
			default: cmd = '0;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/sgl_dp.sv
// Datapath of the scatter/gather list engine: pair table, cursor and result registers.
module sgl_dp
	import sgl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [0:0] m_axis_tuser,
	input  sgl_cmd_t cmd,
	output sgl_stat_t stat
);

	// Pair table
	sgl_entry_t mem [TABLE_DEPTH];
	sgl_entry_t rd_q;
	logic rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	sgl_entry_t wr_data;

	// Control state
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cursor_q;
	logic [LEN_W-1:0] bytes_q;
	logic [ADDR_W-1:0] merge_q;

	// Captured item
	sgl_op_t op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] max_q;
	logic opt_q;

	// Fragment work registers
	logic [ADDR_W-1:0] frag_addr_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] m1;
	logic [LEN_W-1:0] capv;
	logic [LEN_W-1:0] frag_len;

	// Result registers
	logic res_fail_q;
	logic res_frag_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [LEN_W-1:0] res_len_q;

	logic [CNT_W-1:0] last_cnt;

	assign last_cnt = count_q - CNT_W'(1);

	// Status for the controller
	assign stat.op = op_q;
	assign stat.can_merge = (count_q != '0) && !opt_q && (merge_q == addr_q);
	assign stat.full = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= 32'(TABLE_DEPTH));
	assign stat.get_none = (count_q == '0) || (32'(cursor_q) >= 32'(count_q));
	assign stat.rem_zero = (rd_q.len == bytes_q);
	assign stat.last_pair = (32'(cursor_q) + 32'd1) >= 32'(count_q);

	// Table read address: last pair for append, cursor pair for get, the pair after the cursor on a get step
	always_comb begin
		rd_en = cmd.rd_look || cmd.rd_step;
		if (cmd.rd_step) begin
			rd_idx = cursor_q + IDX_W'(1);
		end else if (op_q == OP_APPEND) begin
			rd_idx = last_cnt[IDX_W-1:0];
		end else begin
			rd_idx = cursor_q;
		end
	end

	// Table write: grow the last pair or store a new one
	always_comb begin
		wr_en = cmd.app_merge || cmd.app_new;
		if (cmd.app_merge) begin
			wr_idx = last_cnt[IDX_W-1:0];
			wr_data.addr = rd_q.addr;
			wr_data.len = rd_q.len + len_q;
		end else begin
			wr_idx = count_q[IDX_W-1:0];
			wr_data.addr = addr_q;
			wr_data.len = len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rd_q <= mem[rd_idx];
	end

	// Fragment cap: none for a zero max, a plain cap, or stop at a power-of-two boundary
	always_comb begin
		m1 = max_q - LEN_W'(1);
		if ((max_q & m1) == '0) begin
			capv = max_q - (frag_addr_q[LEN_W-1:0] & m1);
		end else begin
			capv = max_q;
		end
		if ((max_q != '0) && (capv < rem_q)) begin
			frag_len = capv;
		end else begin
			frag_len = rem_q;
		end
	end

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			op_q <= sgl_op_t'(s_axis_tuser);
			addr_q <= s_axis_tdata[63:0];
			len_q <= s_axis_tdata[95:64];
			max_q <= s_axis_tdata[127:96];
			opt_q <= s_axis_tdata[128];
		end
	end

	// Fragment address and remaining length, then result and output beat
	always_ff @(posedge clk) begin
		if (cmd.frag_ld) begin
			frag_addr_q <= rd_q.addr + ADDR_W'(bytes_q);
			rem_q <= rd_q.len - bytes_q;
		end
		if (cmd.res_fail || cmd.res_zero) begin
			res_fail_q <= cmd.res_fail;
			res_frag_q <= 1'b0;
			res_addr_q <= '0;
			res_len_q <= '0;
		end else if (cmd.cap_ld) begin
			res_fail_q <= 1'b0;
			res_frag_q <= 1'b1;
			res_addr_q <= frag_addr_q;
			res_len_q <= frag_len;
		end
		if (cmd.out_ld) begin
			m_axis_tdata <= {res_len_q, res_addr_q};
			m_axis_tuser <= res_fail_q;
		end
	end

	// Count, cursor, merge point and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			count_q <= '0;
			cursor_q <= '0;
			bytes_q <= '0;
			merge_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.clr) count_q <= '0;
			else if (cmd.app_new) count_q <= count_q + CNT_W'(1);
			if (cmd.app_merge || cmd.app_new) merge_q <= addr_q + ADDR_W'(len_q);
			if (cmd.clr || cmd.rewind) begin
				cursor_q <= '0;
				bytes_q <= '0;
			end else if (cmd.get_step) begin
				cursor_q <= cursor_q + IDX_W'(1);
				bytes_q <= '0;
			end else if (cmd.out_ld && res_frag_q && !opt_q) begin
				bytes_q <= bytes_q + res_len_q;
			end
		end
	end

endmodule

>>> rtl/scatter_gather_list_engine_top.sv
// Top level of the scatter/gather list engine: controller plus datapath.
//
// One command beat in, one result beat out. The table holds up to 64 address/length pairs in a
// single-port memory with a registered read, and one command is worked at a time. Clear,
// rewind, append and a failing get pass through the table read, the decision and the output
// register load before the next beat is taken; a get that returns a fragment passes through
// the table read, the decision (which, when the current pair is used up, also reads the next
// pair), the fragment address add, the length cap and the output register load. A finished
// result waits in the output register while the next command beat is taken; the result stage
// of that next command holds until the output register is free. The table needs no clearing
// after reset. capacity_limit resets to 64 and is to be written through cfg_we/cfg_wdata only
// while no command is in flight; the block itself does not enforce this.
module scatter_gather_list_engine_top
	import sgl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,            // capacity_limit
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// in_address, in_length, max_length, option_bit, pad
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,               // cmd
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,    // out_address, out_length
	output logic [0:0] m_axis_tuser                // status
);

	sgl_cmd_t cmd;
	sgl_stat_t stat;

	sgl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.stat(stat),
		.cmd(cmd)
	);

	sgl_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cmd(cmd),
		.stat(stat)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench for the scatter/gather list engine top level.
`timescale 1ns / 100ps

module tb;
	import sgl_pkg::*;

	// One command beat and one result beat as the testbench sees them
	typedef struct {
		sgl_op_t op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] max_len;
		logic opt;
	} sgl_item_t;

	typedef struct {
		logic status;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0] len;
	} sgl_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = CAP_RESET;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;      // in_address, in_length, max_length, option_bit, pad
	logic [1:0] s_axis_tuser = OP_CLEAR;          // cmd
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // out_address, out_length
	logic [0:0] m_axis_tuser;                    // status

	scatter_gather_list_engine_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Shadow copy of the pair table, cursor and capacity
	logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
	logic [LEN_W-1:0] tbl_len [TABLE_DEPTH];
	int unsigned tbl_count = 0;
	int unsigned cur_idx = 0;
	logic [LEN_W-1:0] cur_bytes = '0;
	logic [ADDR_W-1:0] cont_addr = '0;
	int unsigned cap_now = 64;

	sgl_item_t cmd_q [$];
	sgl_result_t frag_q [$];
	sgl_item_t cur_item;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_arm = 1'b0;
	int unsigned hold_left = 0;

	int errors = 0;
	int n_cmds = 0;
	int n_results = 0;
	int n_append = 0;
	int n_get = 0;
	int n_frag = 0;
	int n_merge = 0;
	int n_full = 0;
	int n_get_fail = 0;
	logic [ADDR_W-1:0] gen_next_addr = 64'h1000;

	// Work out the result of one command and advance the shadow state
	function automatic sgl_result_t predict_sgl(input sgl_item_t it);
		sgl_result_t r;
		int unsigned lim;
		int unsigned idx;
		logic [LEN_W-1:0] rem;
		logic [LEN_W-1:0] bytes;
		logic [LEN_W-1:0] m1;
		logic [LEN_W-1:0] clip;
		logic [ADDR_W-1:0] fa;
		r = '{status: 1'b0, addr: '0, len: '0};
		case (it.op)
			OP_CLEAR: begin
				tbl_count = 0;
				cur_idx = 0;
				cur_bytes = '0;
			end
			OP_REWIND: begin
				cur_idx = 0;
				cur_bytes = '0;
			end
			OP_APPEND: begin
				n_append++;
				lim = (cap_now > TABLE_DEPTH) ? TABLE_DEPTH : cap_now;
				if (tbl_count > 0 && !it.opt && cont_addr == it.addr) begin
					tbl_len[tbl_count-1] = tbl_len[tbl_count-1] + it.len;
					cont_addr = it.addr + ADDR_W'(it.len);
					n_merge++;
				end else if (tbl_count >= lim) begin
					r.status = 1'b1;
					n_full++;
				end else begin
					tbl_addr[tbl_count] = it.addr;
					tbl_len[tbl_count] = it.len;
					tbl_count++;
					cont_addr = it.addr + ADDR_W'(it.len);
				end
			end
			default: begin
				n_get++;
				idx = cur_idx;
				bytes = cur_bytes;
				if (idx >= tbl_count) begin
					r.status = 1'b1;
				end else begin
					rem = tbl_len[idx] - bytes;
					// step past a used-up pair, or stop at the end of the list
					if (rem == '0) begin
						if (idx + 1 >= tbl_count) begin
							r.status = 1'b1;
						end else begin
							idx++;
							bytes = '0;
							cur_idx = idx;
							cur_bytes = '0;
							rem = tbl_len[idx];
						end
					end
				end
				if (!r.status) begin
					fa = tbl_addr[idx] + ADDR_W'(bytes);
					if (it.max_len != '0) begin
						m1 = it.max_len - 1;
						clip = it.max_len;
						if ((it.max_len & m1) == '0)
							clip = it.max_len - (fa[LEN_W-1:0] & m1);
						if (clip < rem)
							rem = clip;
					end
					if (!it.opt)
						cur_bytes = bytes + rem;
					r.addr = fa;
					r.len = rem;
					n_frag++;
				end else begin
					n_get_fail++;
				end
			end
		endcase
		return r;
	endfunction

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("tb: ERROR at %0t: %s", $realtime, msg);
	endtask

	// Command driver: predict on each accepted beat, then offer the next one
	always @(posedge clk) begin : cmd_driver
		if (s_axis_tvalid && s_axis_tready) begin
			frag_q.push_back(predict_sgl(cur_item));
			n_cmds++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_item = cmd_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'b0, cur_item.opt, cur_item.max_len, cur_item.len,
					cur_item.addr};
				s_axis_tuser <= cur_item.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_monitor
		sgl_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (frag_q.size() == 0) begin
				note_error($sformatf("result beat with nothing outstanding: st %0d addr %h len %h",
					m_axis_tuser[0], m_axis_tdata[63:0], m_axis_tdata[95:64]));
			end else begin
				want = frag_q.pop_front();
				if (m_axis_tuser[0] !== want.status || m_axis_tdata[63:0] !== want.addr ||
						m_axis_tdata[95:64] !== want.len)
					note_error($sformatf("exp st %0d addr %h len %h, got st %0d addr %h len %h",
						want.status, want.addr, want.len, m_axis_tuser[0],
						m_axis_tdata[63:0], m_axis_tdata[95:64]));
			end
		end
		if (hold_left != 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_arm)
			hold_left <= 320;
	end

	task automatic push_cmd(input sgl_op_t op, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] max_len, input logic opt);
		sgl_item_t it;
		it = '{op: op, addr: addr, len: len, max_len: max_len, opt: opt};
		cmd_q.push_back(it);
	endtask

	// Wait until every command is taken and every result is back
	task automatic drain();
		@(negedge clk);
		while (cmd_q.size() != 0 || s_axis_tvalid || frag_q.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_cap(input int unsigned v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CAP_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_now = v;
		@(negedge clk);
	endtask

	// Random commands: mostly list building and walking, some clears and rewinds
	task automatic push_random(input int n);
		int sel;
		int pick;
		logic [ADDR_W-1:0] a;
		logic [LEN_W-1:0] l;
		logic [LEN_W-1:0] m;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				push_cmd(OP_CLEAR, {$urandom, $urandom}, $urandom, $urandom,
					1'($urandom_range(0, 1)));
			end else if (sel < 8) begin
				push_cmd(OP_REWIND, {$urandom, $urandom}, $urandom, $urandom,
					1'($urandom_range(0, 1)));
			end else if (sel < 50) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					a = gen_next_addr;
				else if (pick < 80)
					a = ADDR_W'($urandom_range(0, 65535)) << 4;
				else
					a = {$urandom, $urandom};
				pick = $urandom_range(0, 99);
				if (pick < 70)
					l = $urandom_range(0, 300);
				else if (pick < 85)
					l = $urandom_range(0, 65535);
				else if (pick < 95)
					l = $urandom;
				else
					l = '0;
				gen_next_addr = a + ADDR_W'(l);
				push_cmd(OP_APPEND, a, l, $urandom, $urandom_range(0, 99) < 20);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					m = '0;
				else if (pick < 60)
					m = 32'd1 << $urandom_range(0, 31);
				else if (pick < 85)
					m = $urandom_range(1, 200);
				else
					m = $urandom;
				push_cmd(OP_GET, {$urandom, $urandom}, $urandom, m, $urandom_range(0, 99) < 15);
			end
		end
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input int unsigned cap,
			input int n, input bit squeeze);
		set_cap(cap);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		push_random(n);
		if (squeeze) begin
			hold_arm = 1'b1;
			@(negedge clk);
			hold_arm = 1'b0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// Directed: empty table, wraps, boundary caps, end of list, zero-length pair
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_REWIND, '0, '0, '0, 1'b0);
		push_cmd(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFF0, 32'h20, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, 32'h20, 1'b0);
		push_cmd(OP_GET, '0, '0, 32'h20, 1'b0);
		push_cmd(OP_APPEND, 64'h10, 32'hFFFF_FFF0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b1);
		push_cmd(OP_GET, '0, '0, 32'hFFFF_FFFF, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_APPEND, 64'h1_0000_0000, 32'd5, '0, 1'b1);
		push_cmd(OP_GET, '0, '0, 32'h8000_0000, 1'b1);
		push_cmd(OP_APPEND, 64'h1_0000_0005, '0, '0, 1'b0);
		push_cmd(OP_APPEND, 64'h2000, '0, '0, 1'b1);
		push_cmd(OP_GET, '0, '0, 32'd1, 1'b0);
		push_cmd(OP_GET, '0, '0, 32'd3, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_REWIND, '0, '0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b1);
		push_cmd(OP_CLEAR, '1, '1, '1, 1'b1);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_APPEND, '1, '1, '1, 1'b1);
		push_cmd(OP_GET, '1, '1, '1, 1'b1);

		// Full table at capacity one: refuse a new pair, still merge
		set_cap(1);
		push_cmd(OP_APPEND, 64'h4000, 32'd8, '0, 1'b1);
		push_cmd(OP_APPEND, 64'h0000_0000_FFFF_FFFE, 32'd2, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		set_cap(64);
		push_cmd(OP_APPEND, 64'h100, 32'h40, '0, 1'b1);
		push_cmd(OP_APPEND, 64'h200, 32'h10, '0, 1'b1);

		// Limit lowered below the stored count: pairs stay readable
		set_cap(2);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, '0, 1'b0);
		push_cmd(OP_GET, '0, '0, 32'h8, 1'b0);
		push_cmd(OP_APPEND, 64'h300, 32'h10, '0, 1'b1);
		push_cmd(OP_REWIND, '0, '0, '0, 1'b0);

		// Random phases across idle patterns and capacities
		run_phase(0, 0, 64, 140, 1'b1);
		run_phase(59, 0, 1, 140, 1'b0);
		run_phase(0, 59, 12, 140, 1'b0);
		run_phase(33, 33, 33, 140, 1'b0);
		run_phase(0, 0, 2, 140, 1'b0);
		run_phase(59, 0, 17, 140, 1'b0);
		run_phase(0, 59, 64, 140, 1'b0);
		run_phase(33, 33, 64, 140, 1'b0);
		drain();

		$display("tb: %0d commands (%0d appends, %0d gets), %0d results checked",
			n_cmds, n_append, n_get, n_results);
		$display("tb: %0d fragments, %0d merges, %0d full refusals, %0d failed gets",
			n_frag, n_merge, n_full, n_get_fail);
		if (errors == 0 && frag_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5_000_000;
		$display("tb: timeout with %0d results outstanding", frag_q.size());
		$display("tb: done, errors");
		$finish;
	end

endmodule
